// ===== hdl/wrpe_pkg.sv =====
// Package: shared constants, types and command/status structs for the RMS/peak envelope unit.
package wrpe_pkg;

    localparam int MAX_WINDOW_DEF   = 4096;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int CFG_WIDTH   = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int WIN_W       = 13;
    localparam int HOP_W       = 16;
    localparam int RES_W       = 16;
    localparam int OFS_W       = 18;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOP    = 1'd1;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 13'd1024;
    localparam logic [HOP_W-1:0] HOP_RESET    = 16'd512;

    // Commands from controller to datapath
    typedef struct packed {
        logic write_sample;   // store the incoming sample, set up the frame
        logic walk_start;     // clear accumulators, issue first ring read
        logic walk_step;      // accumulate one ring read, issue next
        logic div_start;      // start mean-square divide
        logic div_step;       // one quotient bit
        logic sqrt_start;     // start root extraction
        logic sqrt_step;      // one root bit
        logic load_out;       // move results to the output register
    } wrpe_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic emit;       // current sample closes a frame
        logic walk_done;  // final ring read accumulated
        logic div_done;
        logic sqrt_done;
    } wrpe_sts_t;

endpackage

// ===== hdl/wrpe_datapath.sv =====
// Datapath: sample ring, frame tracking, window walk, divider and square root.
module wrpe_datapath #(
    parameter int MAX_WINDOW   = wrpe_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = wrpe_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [wrpe_pkg::WIN_W-1:0]    window_length,
    input  logic [wrpe_pkg::HOP_W-1:0]    hop_length,
    input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
    input  logic                          in_last,
    input  wrpe_pkg::wrpe_cmd_t           cmd,
    output wrpe_pkg::wrpe_sts_t           sts,
    output logic [wrpe_pkg::RES_W-1:0]    rms,
    output logic [wrpe_pkg::RES_W-1:0]    peak,
    output logic [wrpe_pkg::WIN_W-1:0]    frame_length,
    output logic                          final_res
);
    import wrpe_pkg::*;

    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int MAG_W = SAMPLE_WIDTH;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SUM_W = SQ_W + LEN_W;
    localparam int RT_W  = SQ_W / 2 + 1;
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam int RCNT_W = $clog2(RT_W + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WINDOW - 1);

    // Sample ring
    logic signed [SAMPLE_WIDTH-1:0] ring [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0] wr_idx_reg, rd_idx_reg;

    // Frame tracking
    logic signed [OFS_W-1:0] offset_reg;
    logic [LEN_W-1:0] len_reg, cnt_reg;
    logic last_reg, rd_pending_reg;

    // Accumulators
    logic [SUM_W-1:0] sum_reg;
    logic [MAG_W-1:0] pk_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [MAG_W-1:0] sq_mag_reg;
    logic             sq_valid_reg;

    // Divider and root
    logic [SUM_W-1:0] quo_reg, rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [SQ_W+1:0] rv_reg;     // radicand shift
    logic [RT_W+1:0] rrem_reg;
    logic [RT_W-1:0] root_reg;
    logic [RCNT_W-1:0] rcnt_reg;

    // Effective window and hop
    logic [LEN_W-1:0] win_eff;
    logic [HOP_W-1:0] hop_eff;
    always_comb
    begin
        if (window_length == '0)
            win_eff = LEN_W'(1);
        else if (32'(window_length) > MAX_WINDOW)
            win_eff = LEN_W'(MAX_WINDOW);
        else
            win_eff = LEN_W'(window_length);
        hop_eff = (hop_length == '0) ? HOP_W'(1) : hop_length;
    end

    // Frame length for the incoming sample
    logic signed [OFS_W-1:0] win_m1;
    logic full_frame, emit_now;
    logic [LEN_W-1:0] len_now;
    always_comb
    begin
        win_m1     = OFS_W'(win_eff) - OFS_W'(1);
        full_frame = offset_reg >= win_m1;
        if (full_frame)
            len_now = win_eff;
        else
            len_now = LEN_W'(offset_reg + OFS_W'(1));
        emit_now = full_frame || (in_last && !offset_reg[OFS_W-1]);
    end
    assign sts.emit = emit_now;

    // Ring write and read port
    always_ff @(posedge clk)
    begin
        if (cmd.write_sample)
            ring[wr_idx_reg] <= in_sample;
        rd_data_reg <= ring[rd_idx_reg];
    end

    // Frame offset, write index, walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            cnt_reg        <= '0;
            rd_pending_reg <= 1'b0;
            sq_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.write_sample)
            begin
                rd_idx_reg <= wr_idx_reg;
                if (in_last)
                begin
                    offset_reg <= '0;
                    wr_idx_reg <= '0;
                end
                else
                begin
                    wr_idx_reg <= (wr_idx_reg == LAST_ADDR) ? '0 : wr_idx_reg + AW'(1);
                    if (full_frame)
                        offset_reg <= offset_reg + OFS_W'(1) - OFS_W'(hop_eff);
                    else
                        offset_reg <= offset_reg + OFS_W'(1);
                end
            end
            // Read address steps backward every walk cycle
            if (cmd.walk_start || cmd.walk_step)
                rd_idx_reg <= (rd_idx_reg == '0) ? LAST_ADDR : rd_idx_reg - AW'(1);
            if (cmd.walk_start)
            begin
                cnt_reg        <= '0;
                rd_pending_reg <= 1'b1;
                sq_valid_reg   <= 1'b0;
            end
            else if (cmd.walk_step)
            begin
                // data for read issued last cycle is in rd_data_reg now
                sq_valid_reg <= rd_pending_reg;
                if (rd_pending_reg)
                begin
                    cnt_reg <= cnt_reg + LEN_W'(1);
                    if (cnt_reg + LEN_W'(1) == len_reg)
                        rd_pending_reg <= 1'b0;
                end
            end
        end
    end

    // Magnitude of the read sample, squared one stage later
    logic [MAG_W-1:0] mag;
    always_comb
    begin
        mag = rd_data_reg[SAMPLE_WIDTH-1] ? MAG_W'(-rd_data_reg) : MAG_W'(rd_data_reg);
    end

    assign sts.walk_done = cmd.walk_step && !rd_pending_reg && sq_valid_reg;

    // Accumulate squares and peak
    always_ff @(posedge clk)
    begin
        if (cmd.write_sample)
        begin
            len_reg  <= len_now;
            last_reg <= in_last;
        end
        if (cmd.walk_start)
        begin
            sum_reg <= '0;
            pk_reg  <= '0;
        end
        else if (cmd.walk_step)
        begin
            if (rd_pending_reg)
            begin
                sq_reg     <= mag * mag;
                sq_mag_reg <= mag;
            end
            if (sq_valid_reg)
            begin
                sum_reg <= sum_reg + SUM_W'(sq_reg);
                if (sq_mag_reg > pk_reg)
                    pk_reg <= sq_mag_reg;
            end
        end
    end

    // Restoring divider: one quotient bit per cycle
    logic [SUM_W:0] rem_sh;
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[SUM_W-1]};
    end
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg  <= sum_reg;
            rem_reg  <= '0;
            dcnt_reg <= DCNT_W'(SUM_W);
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
            if (rem_sh >= (SUM_W + 1)'(len_reg))
            begin
                rem_reg <= SUM_W'(rem_sh - (SUM_W + 1)'(len_reg));
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= SUM_W'(rem_sh);
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end
    assign sts.div_done = (dcnt_reg == '0);

    // Digit-by-digit square root, one root bit per cycle
    logic [RT_W+1:0] trial, rrem_sh;
    always_comb
    begin
        rrem_sh = {rrem_reg[RT_W-1:0], rv_reg[SQ_W+1:SQ_W]};
        trial   = {root_reg, 2'b01};
    end
    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            // mean square fits in SQ_W bits
            rv_reg   <= {2'b00, quo_reg[SQ_W-1:0]};
            rrem_reg <= '0;
            root_reg <= '0;
            rcnt_reg <= RCNT_W'(RT_W);
        end
        else if (cmd.sqrt_step)
        begin
            rcnt_reg <= rcnt_reg - RCNT_W'(1);
            rv_reg   <= {rv_reg[SQ_W-1:0], 2'b00};
            if (rrem_sh >= trial)
            begin
                rrem_reg <= rrem_sh - trial;
                root_reg <= {root_reg[RT_W-2:0], 1'b1};
            end
            else
            begin
                rrem_reg <= rrem_sh;
                root_reg <= {root_reg[RT_W-2:0], 1'b0};
            end
        end
    end
    assign sts.sqrt_done = (rcnt_reg == '0);

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rms          <= RES_W'(root_reg);
            peak         <= RES_W'(pk_reg);
            frame_length <= WIN_W'(len_reg);
            final_res    <= last_reg;
        end
    end
endmodule

// ===== hdl/wrpe_ctrl.sv =====
// Controller: sequences sample write, window walk, divide, root and output handoff.
module wrpe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  wrpe_pkg::wrpe_sts_t sts,
    output wrpe_pkg::wrpe_cmd_t cmd
);
    import wrpe_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;
    localparam logic [2:0] ST_DIVS = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;
    // High in the first walk cycle, the one right after the sample write
    logic walk_start_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.write_sample = 1'b1;
                    if (sts.emit)
                        state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_start_reg)
                    cmd.walk_start = 1'b1;
                else
                begin
                    cmd.walk_step = 1'b1;
                    if (sts.walk_done)
                        state_next = ST_DIVS;
                end
            end
            ST_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
                else
                    cmd.div_step = 1'b1;
            end
            ST_SQRT:
            begin
                if (sts.sqrt_done)
                    state_next = ST_OUT;
                else
                    cmd.sqrt_step = 1'b1;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State, output valid and walk start pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            walk_start_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            walk_start_reg <= accept && sts.emit;
        end
    end
endmodule

// ===== hdl/windowed_rms_peak_envelope_unit.sv =====
// Top level: windowed RMS and peak envelope unit.
// A sample that closes no frame is taken without holding the input. A sample that
// closes a frame holds the input through the ring walk (one ring read per cycle),
// the divide setup, the bit-serial divide, the bit-serial square root and the
// output handoff; the handoff waits as long as an earlier result still sits
// unaccepted in the output register. The result sits in that register while the
// next samples are accepted. The sample ring has no reset; frames read only
// samples written since the stream began.
module windowed_rms_peak_envelope_unit #(
    parameter int MAX_WINDOW   = wrpe_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = wrpe_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [wrpe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wrpe_pkg::CFG_WIDTH-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [wrpe_pkg::RES_W-1:0]     rms,
    output logic [wrpe_pkg::RES_W-1:0]     peak,
    output logic [wrpe_pkg::WIN_W-1:0]     frame_length,
    output logic                           final_res
);
    import wrpe_pkg::*;

    logic [WIN_W-1:0] window_reg;
    logic [HOP_W-1:0] hop_reg;
    wrpe_cmd_t cmd;
    wrpe_sts_t sts;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            hop_reg    <= HOP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW: window_reg <= cfg_data[WIN_W-1:0];
                REG_HOP:    hop_reg    <= cfg_data[HOP_W-1:0];
                default:    ;
            endcase
        end
    end

    wrpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    wrpe_datapath #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (window_reg),
        .hop_length    (hop_reg),
        .in_sample     (sample),
        .in_last       (last),
        .cmd           (cmd),
        .sts           (sts),
        .rms           (rms),
        .peak          (peak),
        .frame_length  (frame_length),
        .final_res     (final_res)
    );

    // A result never exceeds full scale
    a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (peak <= 16'd32768 && rms <= peak))
        else $error("peak or rms out of range");

    // Input is held off once a sample that closes a frame has been written
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write_sample && sts.emit) |=> in_stall)
        else $error("input accepted during frame computation");

    // A result stays put while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(rms) && $stable(peak)))
        else $error("stalled result changed");

endmodule

// ===== tb/tb_windowed_rms_peak_envelope_unit.sv =====
// Self-checking testbench for the windowed RMS and peak envelope unit.
`timescale 1ns / 100ps

module tb_windowed_rms_peak_envelope_unit;
    import wrpe_pkg::*;

    localparam int RING_DEPTH = MAX_WINDOW_DEF;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic [RES_W-1:0] rms;
        logic [RES_W-1:0] peak;
        logic [WIN_W-1:0] frame_length;
        logic             final_res;
    } envelope_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]   cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [15:0]     sample;
    logic                   last;
    logic                   out_valid;
    logic                   out_stall;
    logic [RES_W-1:0]       rms;
    logic [RES_W-1:0]       peak;
    logic [WIN_W-1:0]       frame_length;
    logic                   final_res;

    windowed_rms_peak_envelope_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last(last),
        .out_valid(out_valid), .out_stall(out_stall), .rms(rms), .peak(peak),
        .frame_length(frame_length), .final_res(final_res)
    );

    // Predictor state
    logic signed [15:0] history [RING_DEPTH];
    int                 offset_in_frame;
    int                 ring_wr;
    logic [WIN_W-1:0]   window_reg;
    logic [HOP_W-1:0]   hop_reg;
    envelope_t          pending_frames [$];

    int  errors;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [RES_W-1:0] int_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v -= root + b;
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root[RES_W-1:0];
    endfunction

    // Model one accepted sample; may queue one expected frame
    function automatic void predict_envelope(input logic signed [15:0] s, input logic lst);
        int win;
        int hop;
        int len;
        int idx;
        int a;
        int pk;
        longint unsigned sum;
        envelope_t e;
        win = window_reg;
        hop = hop_reg;
        len = 0;
        if (win < 1) win = 1;
        if (win > RING_DEPTH) win = RING_DEPTH;
        if (hop < 1) hop = 1;
        idx = ring_wr;
        history[idx] = s;
        ring_wr = (ring_wr + 1 >= RING_DEPTH) ? 0 : ring_wr + 1;
        if (offset_in_frame >= win - 1)
            len = win;
        else if (lst && offset_in_frame >= 0)
            len = offset_in_frame + 1;
        if (len > 0)
        begin
            sum = 0;
            pk = 0;
            for (int k = 0; k < len; k++)
            begin
                a = history[idx] < 0 ? -int'(history[idx]) : int'(history[idx]);
                sum += longint'(a) * a;
                if (a > pk) pk = a;
                idx = (idx == 0) ? RING_DEPTH - 1 : idx - 1;
            end
            e.rms = int_root(sum / len);
            e.peak = pk[RES_W-1:0];
            e.frame_length = len[WIN_W-1:0];
            e.final_res = lst;
            pending_frames = {pending_frames, e};
        end
        if (lst)
        begin
            offset_in_frame = 0;
            ring_wr = 0;
        end
        else if (offset_in_frame >= win - 1)
            offset_in_frame = offset_in_frame + 1 - hop;
        else
            offset_in_frame++;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        envelope_t exp_e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frames.size() == 0)
            begin
                $display("%0t: unexpected frame rms=%0d peak=%0d len=%0d final=%0d",
                         $time, rms, peak, frame_length, final_res);
                errors++;
            end
            else
            begin
                exp_e = pending_frames.pop_front();
                if (rms !== exp_e.rms)
                begin
                    $display("%0t: rms expected %0d actual %0d", $time, exp_e.rms, rms);
                    errors++;
                end
                if (peak !== exp_e.peak)
                begin
                    $display("%0t: peak expected %0d actual %0d", $time, exp_e.peak, peak);
                    errors++;
                end
                if (frame_length !== exp_e.frame_length)
                begin
                    $display("%0t: frame_length expected %0d actual %0d", $time,
                             exp_e.frame_length, frame_length);
                    errors++;
                end
                if (final_res !== exp_e.final_res)
                begin
                    $display("%0t: final_res expected %0d actual %0d", $time,
                             exp_e.final_res, final_res);
                    errors++;
                end
            end
        end
    end

    // Receiver stall generation
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("tb_windowed_rms_peak_envelope_unit NOT OK");
            $finish;
        end
    end

    // Send one sample, honoring the sender idle rate; valid stays up afterwards
    // until the next call or a drain takes it down
    task automatic send_sample(input logic signed [15:0] s, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        last <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_envelope(s, lst);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_frames.size() != 0 && guard < 4 * STALL_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        // let a frame-free sample finish, plus worst-case walk
        repeat (RING_DEPTH + 120) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_WIDTH-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW)
            window_reg = val[WIN_W-1:0];
        else
            hop_reg = val[HOP_W-1:0];
    endtask

    task automatic set_shape(input int win, input int hop);
        drain();
        write_reg(REG_WINDOW, win);
        write_reg(REG_HOP, hop);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'(int'($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // Directed: extreme samples, short frames, truncated final, gaps
    task automatic test_directed;
        set_shape(3, 2);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shFFFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        // window zero acts as one, hop zero acts as one
        set_shape(0, 0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh1234, 1'b1);
        // gaps, last sample within a gap
        set_shape(2, 5);
        for (int i = 0; i < 6; i++)
            send_sample(rand_sample(), 1'b0);
        send_sample(16'sh7FFF, 1'b1);
        // oversized window request clamps; ended early
        set_shape(8191, 65535);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh4000, 1'b1);
        // window shrunk mid-stream
        set_shape(6, 1);
        for (int i = 0; i < 4; i++)
            send_sample(rand_sample(), 1'b0);
        drain();
        write_reg(REG_WINDOW, 2);
        send_sample(rand_sample(), 1'b0);
        send_sample(rand_sample(), 1'b1);
    endtask

    // Random streams of random length with random final flag
    task automatic test_random_streams(input int n_items, input int max_win);
        int count;
        int stream_len;
        count = 0;
        while (count < n_items)
        begin
            stream_len = $urandom_range(3 * max_win + 4, 1);
            for (int i = 0; i < stream_len && count < n_items; i++)
            begin
                send_sample(rand_sample(), (i == stream_len - 1));
                count++;
            end
        end
    endtask

    // Receiver holds off while sender keeps offering; then sender waits out drain
    task automatic test_back_pressure;
        set_shape(1, 1);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 30; i++)
                    send_sample(rand_sample(), (i == 29));
                in_valid <= 1'b0;
            end
        join
        drain();
        test_random_streams(20, 4);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WINDOW;
        cfg_data = '0;
        in_valid = 1'b0;
        sample = '0;
        last = 1'b0;
        errors = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        offset_in_frame = 0;
        ring_wr = 0;
        window_reg = WINDOW_RESET;
        hop_reg = HOP_RESET;
        foreach (history[i]) history[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: short stream ends in a truncated first frame
        test_random_streams(1, 1);
        send_sample(16'sh7FFF, 1'b1);

        test_directed();

        // idling phases over several shapes
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            set_shape($urandom_range(8, 1), $urandom_range(10, 1));
            test_random_streams(150, 8);
            set_shape($urandom_range(40, 2), $urandom_range(20, 1));
            test_random_streams(120, 40);
        end
        send_idle_pct = 0;
        recv_stall_pct = 15;
        set_shape(4096, 4096);
        test_random_streams(60, 4096);
        send_sample(rand_sample(), 1'b1);
        set_shape(4096, 1);
        test_random_streams(8, 4096);
        send_sample(rand_sample(), 1'b1);

        test_back_pressure();

        drain();
        if (errors == 0 && pending_frames.size() == 0)
            $display("tb_windowed_rms_peak_envelope_unit OK");
        else
            $display("tb_windowed_rms_peak_envelope_unit NOT OK");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/wrpe_pkg.sv
hdl/wrpe_datapath.sv
hdl/wrpe_ctrl.sv
hdl/windowed_rms_peak_envelope_unit.sv
tb/tb_windowed_rms_peak_envelope_unit.sv
